// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, widths and codes for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

  localparam int CoordBits    = 16;
  localparam int DiffBits     = CoordBits + 1;
  localparam int ProdBits     = 2 * DiffBits;
  localparam int SumBits      = ProdBits + 2;
  localparam int CrossBits    = ProdBits + 1;
  localparam int CrossMagBits = CrossBits - 1;
  localparam int NumBits      = 2 * CrossMagBits + 2;
  localparam int DsqBits      = 2 * CoordBits + 2;
  localparam int ResBits      = CoordBits + 1;
  localparam int SqRemBits    = ResBits + 2;
  localparam int FrontStages  = 6;

  typedef enum logic [1:0] {
    RegInterior   = 2'd0,
    RegBefore     = 2'd1,
    RegBeyond     = 2'd2,
    RegDegenerate = 2'd3
  } region_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] seg_start_x;
    logic signed [CoordBits-1:0] seg_start_y;
    logic signed [CoordBits-1:0] seg_start_z;
    logic signed [CoordBits-1:0] seg_end_x;
    logic signed [CoordBits-1:0] seg_end_y;
    logic signed [CoordBits-1:0] seg_end_z;
    logic signed [CoordBits-1:0] query_x;
    logic signed [CoordBits-1:0] query_y;
    logic signed [CoordBits-1:0] query_z;
  } in_t;

  typedef struct packed {
    logic [DsqBits-1:0] dist_squared;
    logic [ResBits-1:0] dist_res;
    logic [1:0]         region;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic [DsqBits-1:0] rem;
    logic [DsqBits-1:0] low;
    logic [DsqBits-1:0] quo;
    logic [DsqBits-1:0] divisor;
    region_e            region;
  } div_t;

  typedef struct packed {
    logic                 valid;
    logic [SqRemBits-1:0] rem;
    logic [ResBits-1:0]   root;
    logic [DsqBits-1:0]   x;
    logic [DsqBits-1:0]   dsq;
    region_e              region;
  } sq_t;

endpackage

`default_nettype wire

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Differences, products, sums, region decision and cross-product numerator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_front import psd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire in_t  data_i,
  output div_t      div_o
);

  logic [FrontStages-1:0] vld_q;

  logic signed [DiffBits-1:0] d_q [3];
  logic signed [DiffBits-1:0] e_q [3];
  logic signed [DiffBits-1:0] f_q [3];

  logic signed [ProdBits-1:0] sqd_q [3];
  logic signed [ProdBits-1:0] sqe_q [3];
  logic signed [ProdBits-1:0] sqf_q [3];
  logic signed [ProdBits-1:0] dotp_q [3];
  logic signed [ProdBits-1:0] crs_q [6];

  logic        [SumBits-1:0]   pv2_q, l2_q, f2_q;
  logic signed [SumBits-1:0]   dot_q;
  logic signed [CrossBits-1:0] cr_q [3];

  logic [CrossMagBits-1:0] cmag_q [3];
  logic [SumBits-1:0]      l2b_q, alt_q;
  region_e                 reg4_q;

  logic [2*CrossMagBits-1:0] csq_q [3];
  logic [SumBits-1:0]        l2c_q, altc_q;
  region_e                   reg5_q;

  logic [NumBits-1:0] num_d;
  logic [DsqBits-1:0] divisor_q, rem_q, low_q;
  region_e            reg6_q, reg4_d;

  logic signed [DiffBits-1:0] v_s [3], w_s [3], p_s [3];

  always_comb begin
    v_s[0] = DiffBits'(data_i.seg_start_x);
    v_s[1] = DiffBits'(data_i.seg_start_y);
    v_s[2] = DiffBits'(data_i.seg_start_z);
    w_s[0] = DiffBits'(data_i.seg_end_x);
    w_s[1] = DiffBits'(data_i.seg_end_y);
    w_s[2] = DiffBits'(data_i.seg_end_z);
    p_s[0] = DiffBits'(data_i.query_x);
    p_s[1] = DiffBits'(data_i.query_y);
    p_s[2] = DiffBits'(data_i.query_z);
  end

  always_comb begin
    if (l2_q == '0) begin
      reg4_d = RegDegenerate;
    end else if (dot_q < 0) begin
      reg4_d = RegBefore;
    end else if (dot_q > $signed(l2_q)) begin
      reg4_d = RegBeyond;
    end else begin
      reg4_d = RegInterior;
    end
  end

  always_comb begin
    if (reg5_q == RegInterior) begin
      num_d = NumBits'(csq_q[0]) + NumBits'(csq_q[1]) + NumBits'(csq_q[2]);
    end else begin
      num_d = NumBits'(altc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i]    <= p_s[i] - v_s[i];
        e_q[i]    <= w_s[i] - v_s[i];
        f_q[i]    <= p_s[i] - w_s[i];
        sqd_q[i]  <= d_q[i] * d_q[i];
        sqe_q[i]  <= e_q[i] * e_q[i];
        sqf_q[i]  <= f_q[i] * f_q[i];
        dotp_q[i] <= d_q[i] * e_q[i];
      end
      crs_q[0] <= d_q[1] * e_q[2];
      crs_q[1] <= d_q[2] * e_q[1];
      crs_q[2] <= d_q[2] * e_q[0];
      crs_q[3] <= d_q[0] * e_q[2];
      crs_q[4] <= d_q[0] * e_q[1];
      crs_q[5] <= d_q[1] * e_q[0];

      pv2_q <= SumBits'($unsigned(sqd_q[0])) + SumBits'($unsigned(sqd_q[1]))
             + SumBits'($unsigned(sqd_q[2]));
      l2_q  <= SumBits'($unsigned(sqe_q[0])) + SumBits'($unsigned(sqe_q[1]))
             + SumBits'($unsigned(sqe_q[2]));
      f2_q  <= SumBits'($unsigned(sqf_q[0])) + SumBits'($unsigned(sqf_q[1]))
             + SumBits'($unsigned(sqf_q[2]));
      dot_q <= SumBits'(dotp_q[0]) + SumBits'(dotp_q[1]) + SumBits'(dotp_q[2]);
      for (int i = 0; i < 3; i++) begin
        cr_q[i] <= CrossBits'(crs_q[2*i]) - CrossBits'(crs_q[2*i+1]);
      end

      for (int i = 0; i < 3; i++) begin
        cmag_q[i] <= cr_q[i][CrossBits-1] ? CrossMagBits'(-cr_q[i])
                                          : CrossMagBits'(cr_q[i]);
      end
      l2b_q  <= l2_q;
      alt_q  <= (reg4_d == RegBeyond) ? f2_q : pv2_q;
      reg4_q <= reg4_d;

      for (int i = 0; i < 3; i++) begin
        csq_q[i] <= cmag_q[i] * cmag_q[i];
      end
      l2c_q  <= l2b_q;
      altc_q <= alt_q;
      reg5_q <= reg4_q;

      divisor_q <= (reg5_q == RegInterior) ? DsqBits'(l2c_q) : DsqBits'(1);
      rem_q     <= DsqBits'(num_d[NumBits-1:DsqBits]);
      low_q     <= num_d[DsqBits-1:0];
      reg6_q    <= reg5_q;
    end
  end

  assign div_o.valid   = vld_q[FrontStages-1];
  assign div_o.rem     = rem_q;
  assign div_o.low     = low_q;
  assign div_o.quo     = '0;
  assign div_o.divisor = divisor_q;
  assign div_o.region  = reg6_q;

endmodule

`default_nettype wire

// ===== rtl/core/psd_div_cell.sv =====
// ----------------------------------------------------------------------------
// psd_div_cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_div_cell import psd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire div_t prev_i,
  output div_t      next_o
);

  logic [DsqBits:0] trial;
  logic             ge;
  logic             valid_q;
  div_t             step_d, cell_q;

  always_comb begin
    trial  = {prev_i.rem, prev_i.low[DsqBits-1]};
    ge     = trial >= {1'b0, prev_i.divisor};
    step_d = prev_i;
    step_d.rem = ge ? DsqBits'(trial - {1'b0, prev_i.divisor}) : DsqBits'(trial);
    step_d.low = {prev_i.low[DsqBits-2:0], 1'b0};
    step_d.quo = {prev_i.quo[DsqBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= step_d;
    end
  end

  always_comb begin
    next_o       = cell_q;
    next_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/psd_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt_cell
// One digit-by-digit square root step: one root bit per cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_sqrt_cell import psd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire sq_t  prev_i,
  output sq_t       next_o
);

  logic [SqRemBits+1:0] acc, trial;
  logic                 ge;
  logic                 valid_q;
  sq_t                  step_d, cell_q;

  always_comb begin
    acc    = {prev_i.rem, prev_i.x[DsqBits-1 -: 2]};
    trial  = (SqRemBits+2)'({prev_i.root, 2'b01});
    ge     = acc >= trial;
    step_d = prev_i;
    step_d.rem  = ge ? SqRemBits'(acc - trial) : SqRemBits'(acc);
    step_d.root = {prev_i.root[ResBits-2:0], ge};
    step_d.x    = {prev_i.x[DsqBits-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= step_d;
    end
  end

  always_comb begin
    next_o       = cell_q;
    next_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ===== rtl/core/point_segment_distance_3d.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a 3D point to a segment: front pipeline, divider cell chain,
// square root cell chain.
// ----------------------------------------------------------------------------
// Stages: 6 front stages, 34 divider cells, 17 root cells.
// Throughput: one transaction per cycle while the output is not stalled.
// An output stall while a result is valid freezes the whole pipeline and raises in_stall_o.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module point_segment_distance_3d import psd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic en;
  div_t div_chain [DsqBits+1];
  sq_t  sq_chain  [ResBits+1];

  assign en         = !(sq_chain[ResBits].valid && out_stall_i);
  assign in_stall_o = !en;

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .div_o   (div_chain[0])
  );

  for (genvar g = 0; g < DsqBits; g++) begin : g_div
    psd_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .prev_i (div_chain[g]),
      .next_o (div_chain[g+1])
    );
  end

  always_comb begin
    sq_chain[0].valid  = div_chain[DsqBits].valid;
    sq_chain[0].rem    = '0;
    sq_chain[0].root   = '0;
    sq_chain[0].x      = div_chain[DsqBits].quo;
    sq_chain[0].dsq    = div_chain[DsqBits].quo;
    sq_chain[0].region = div_chain[DsqBits].region;
  end

  for (genvar g = 0; g < ResBits; g++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .prev_i (sq_chain[g]),
      .next_o (sq_chain[g+1])
    );
  end

  assign out_valid_o             = sq_chain[ResBits].valid;
  assign out_data_o.dist_squared = sq_chain[ResBits].dsq;
  assign out_data_o.dist_res     = sq_chain[ResBits].root;
  assign out_data_o.region       = sq_chain[ResBits].region;

endmodule

`default_nettype wire

// ===== rtl/core/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the point to segment distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psd_checker import psd_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  logic [2*ResBits-1:0] res_sq, res1_sq;

  assign res_sq  = out_data_o.dist_res * out_data_o.dist_res;
  assign res1_sq = (out_data_o.dist_res + 1'b1) * (out_data_o.dist_res + 1'b1);

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled transaction changed");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DsqBits+2)'(res_sq) <= (DsqBits+2)'(out_data_o.dist_squared)
      && (DsqBits+2)'(res1_sq) > (DsqBits+2)'(out_data_o.dist_squared))
    else $error("dist_res is not the floor square root");

endmodule

bind point_segment_distance_3d psd_checker u_psd_checker (.*);

`default_nettype wire

// ===== tb/point_segment_distance_3d_tb.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_3d_tb
// Drives endpoint and query transactions into the distance pipeline with
// random gaps and output stalls, predicts squared distance, root and region
// with exact wide integer arithmetic, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_segment_distance_3d_tb;
  import psd_pkg::*;

  localparam int Latency    = 57;
  localparam int CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  out_t distance_q[$];
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  bit   idle_en = 1'b1;

  point_segment_distance_3d i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_t predict_distance(in_t t);
    longint dx, dy, dz, ex, ey, ez, fx, fy, fz, l2, pv2, dot;
    logic [127:0] num;
    logic [63:0]  dsq;
    out_t o;
    dx = longint'(t.query_x) - longint'(t.seg_start_x);
    dy = longint'(t.query_y) - longint'(t.seg_start_y);
    dz = longint'(t.query_z) - longint'(t.seg_start_z);
    ex = longint'(t.seg_end_x) - longint'(t.seg_start_x);
    ey = longint'(t.seg_end_y) - longint'(t.seg_start_y);
    ez = longint'(t.seg_end_z) - longint'(t.seg_start_z);
    fx = longint'(t.query_x) - longint'(t.seg_end_x);
    fy = longint'(t.query_y) - longint'(t.seg_end_y);
    fz = longint'(t.query_z) - longint'(t.seg_end_z);
    l2  = ex * ex + ey * ey + ez * ez;
    pv2 = dx * dx + dy * dy + dz * dz;
    dot = dx * ex + dy * ey + dz * ez;
    if (l2 == 0) begin
      dsq = pv2;
      o.region = RegDegenerate;
    end else if (dot < 0) begin
      dsq = pv2;
      o.region = RegBefore;
    end else if (dot > l2) begin
      dsq = fx * fx + fy * fy + fz * fz;
      o.region = RegBeyond;
    end else begin
      num = 128'(pv2) * 128'(l2) - 128'(dot) * 128'(dot);
      dsq = 64'(num / 128'(l2));
      o.region = RegInterior;
    end
    o.dist_squared = dsq[DsqBits-1:0];
    o.dist_res = ResBits'(floor_sqrt(dsq));
    return o;
  endfunction

  task automatic send_query(in_t t);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    distance_q.push_back(predict_distance(t));
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    in_data_i <= '0;
  endtask

  always begin
    @(posedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (distance_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        err_cnt++;
      end else begin
        out_t exp_o;
        exp_o = distance_q.pop_front();
        if (out_data_o.dist_squared !== exp_o.dist_squared) begin
          $display("%0t: dist_squared expected %0d actual %0d", $time,
                   exp_o.dist_squared, out_data_o.dist_squared);
          err_cnt++;
        end
        if (out_data_o.dist_res !== exp_o.dist_res) begin
          $display("%0t: dist_res expected %0d actual %0d", $time,
                   exp_o.dist_res, out_data_o.dist_res);
          err_cnt++;
        end
        if (out_data_o.region !== exp_o.region) begin
          $display("%0t: region expected %0d actual %0d", $time,
                   exp_o.region, out_data_o.region);
          err_cnt++;
        end
      end
    end
  end

  function automatic in_t make_query(int vx, int vy, int vz, int wx, int wy, int wz,
                                     int px, int py, int pz);
    in_t t;
    t.seg_start_x = CoordBits'(vx);
    t.seg_start_y = CoordBits'(vy);
    t.seg_start_z = CoordBits'(vz);
    t.seg_end_x   = CoordBits'(wx);
    t.seg_end_y   = CoordBits'(wy);
    t.seg_end_z   = CoordBits'(wz);
    t.query_x     = CoordBits'(px);
    t.query_y     = CoordBits'(py);
    t.query_z     = CoordBits'(pz);
    return t;
  endfunction

  function automatic logic signed [15:0] rand_coord(int span);
    if (span == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic test_directed();
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(5, 5, 5, 5, 5, 5, 9, -3, 7));
    send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                          32767, 32767, 32767));
    send_query(make_query(0, 0, 0, 10, 0, 0, -5, 3, 0));
    send_query(make_query(0, 0, 0, 10, 0, 0, 15, 3, 4));
    send_query(make_query(0, 0, 0, 10, 0, 0, 4, 3, 7));
    send_query(make_query(0, 0, 0, 10, 0, 0, 0, 3, 4));
    send_query(make_query(0, 0, 0, 10, 0, 0, 10, 3, 4));
    send_query(make_query(1, 2, 3, 4, 6, 8, 1, 2, 3));
    send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                          32767, -32768, 32767));
    send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767,
                          -32768, 32767, -32768));
    send_query(make_query(32767, 32767, 32767, -32768, -32768, -32768,
                          -32768, -32768, 32767));
    send_query(make_query(-32768, 0, 0, 32767, 0, 0, -32768, 32767, -32768));
    send_query(make_query(32767, -32768, 32767, -32768, 32767, -32768,
                          -32768, -32768, -32768));
    send_query(make_query(-1, -1, -1, 1, 1, 1, 3, -3, 0));
    send_query(make_query(0, 0, 0, 3, 4, 0, 6, 8, 0));
    release_input();
  endtask

  task automatic test_random(int n, int span);
    in_t t;
    repeat (n) begin
      t = make_query(rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span),
                     rand_coord(span), rand_coord(span), rand_coord(span));
      if ($urandom_range(0, 15) == 0) begin
        t.seg_end_x = t.seg_start_x;
        t.seg_end_y = t.seg_start_y;
        t.seg_end_z = t.seg_start_z;
      end
      send_query(t);
    end
    release_input();
  endtask

  task automatic test_no_idle(int n);
    idle_en = 1'b0;
    test_random(n, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300, 0);
    test_random(200, 40);
    test_random(100, 2000);
    test_no_idle(100);
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
